// ===== rtl/spq_pkg.sv =====
// Shared types, codes and defaults for the stable priority queue.
package spq_pkg;

  localparam int CAPACITY_DEFAULT  = 16;
  localparam int PRIO_BITS_DEFAULT = 8;

  localparam int CMD_W        = 2;
  localparam int VALUE_W      = 32;
  localparam int PRIO_FIELD_W = 8;
  localparam int STATUS_W     = 2;
  localparam int COUNT_FIELD_W = 5;

  localparam logic [VALUE_W-1:0] EMPTY_VALUE = {VALUE_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL_DROP = 2'd2;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
// Controller state machine for the stable priority queue.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output spq_pkg::ctl_t ctl
);

  spq_pkg::state_t state_r, state_nxt;
  logic            valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (start) state_nxt = spq_pkg::ST_EXEC;
      end
      spq_pkg::ST_EXEC: begin
        state_nxt = spq_pkg::ST_IDLE;
      end
      default: state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    ctl.load  = 1'b0;
    ctl.exec  = 1'b0;
    valid_nxt = 1'b0;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        ctl.load = start;
      end
      spq_pkg::ST_EXEC: begin
        busy      = 1'b1;
        ctl.exec  = 1'b1;
        valid_nxt = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == spq_pkg::ST_EXEC))
    else $error("accepted word did not start execution");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::ST_EXEC) |=> (valid_r && !busy))
    else $error("execution did not produce exactly one result");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |=> !valid_r)
    else $error("result strobe held longer than one cycle");

endmodule

// ===== rtl/spq_datapath.sv =====
// Slot array with parallel compare-and-shift, count and result registers.
module spq_datapath #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEFAULT,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::ctl_t                       ctl,
  input  logic [spq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_item_value,
  input  logic [spq_pkg::PRIO_FIELD_W-1:0]    in_item_priority,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_front_value,
  output logic [spq_pkg::PRIO_FIELD_W-1:0]    out_front_priority,
  output logic                                out_is_empty,
  output logic [spq_pkg::COUNT_FIELD_W-1:0]   out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [spq_pkg::CMD_W-1:0]    cmd_r;
  logic [spq_pkg::VALUE_W-1:0]  val_r;
  logic [PRIO_BITS-1:0]         prio_r;
  logic [spq_pkg::VALUE_W-1:0]  slot_val_r  [CAPACITY];
  logic [PRIO_BITS-1:0]         slot_prio_r [CAPACITY];
  logic [spq_pkg::VALUE_W-1:0]  slot_val_nxt  [CAPACITY];
  logic [PRIO_BITS-1:0]         slot_prio_nxt [CAPACITY];
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [spq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [CAPACITY-1:0]          ge;
  logic                         empty, full, do_ins, do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign do_ins = (cmd_r == spq_pkg::CMD_INSERT) && !full;
  assign do_pop = (cmd_r == spq_pkg::CMD_POP) && !empty;

  // Each slot decides on its own: keep, take the new word, or shift.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
    assign ge[k] = (CNT_W'(k) < cnt_r) && (slot_prio_r[k] >= prio_r);

    always_comb begin
      slot_val_nxt[k]  = slot_val_r[k];
      slot_prio_nxt[k] = slot_prio_r[k];
      if (do_ins && !ge[k]) begin
        if (k == 0) begin
          slot_val_nxt[k]  = val_r;
          slot_prio_nxt[k] = prio_r;
        end else if (ge[(k == 0) ? 0 : k-1]) begin
          slot_val_nxt[k]  = val_r;
          slot_prio_nxt[k] = prio_r;
        end else begin
          slot_val_nxt[k]  = slot_val_r[(k == 0) ? 0 : k-1];
          slot_prio_nxt[k] = slot_prio_r[(k == 0) ? 0 : k-1];
        end
      end else if (do_pop && (k < CAPACITY - 1)) begin
        slot_val_nxt[k]  = slot_val_r[(k < CAPACITY - 1) ? k+1 : k];
        slot_prio_nxt[k] = slot_prio_r[(k < CAPACITY - 1) ? k+1 : k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.exec) begin
        slot_val_r[k]  <= slot_val_nxt[k];
        slot_prio_r[k] <= slot_prio_nxt[k];
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = spq_pkg::STATUS_OK;
    case (cmd_r)
      spq_pkg::CMD_INSERT: begin
        if (full) status_nxt = spq_pkg::STATUS_FULL_DROP;
        else      cnt_nxt    = cnt_r + CNT_W'(1);
      end
      spq_pkg::CMD_POP: begin
        if (empty) status_nxt = spq_pkg::STATUS_POP_EMPTY;
        else       cnt_nxt    = cnt_r - CNT_W'(1);
      end
      default: status_nxt = spq_pkg::STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      val_r  <= in_item_value;
      prio_r <= PRIO_BITS'(in_item_priority);
    end
    if (ctl.exec) status_r <= status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_status         = status_r;
  assign out_is_empty       = empty;
  assign out_front_value    = empty ? spq_pkg::EMPTY_VALUE : slot_val_r[0];
  assign out_front_priority = empty ? '0 : spq_pkg::PRIO_FIELD_W'(slot_prio_r[0]);
  assign out_entry_count    = spq_pkg::COUNT_FIELD_W'(cnt_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && do_ins) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.exec |=> (cnt_r == $past(cnt_r)))
    else $error("count moved outside execution");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.exec && (cmd_r == spq_pkg::CMD_INSERT) && full)
      |=> (status_r == spq_pkg::STATUS_FULL_DROP) && full)
    else $error("full insert not flagged or not dropped");

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: controller plus slot datapath.
//
//   channel   ports                                   handshake
//   input     in_cmd, in_item_value, in_item_priority start high, busy low
//   result    out_status, out_front_value,            out_valid, one cycle
//             out_front_priority, out_is_empty,
//             out_entry_count
//
// Each word is registered when accepted, then run in the EXEC state, in which
// every slot compares its priority and shifts in parallel. The result strobes
// in the cycle after execute, and a new word may be accepted in that cycle.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// The receiver cannot stall; results are presented for exactly one cycle.
module stable_priority_queue #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEFAULT,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [spq_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_item_value,
  input  logic [spq_pkg::PRIO_FIELD_W-1:0]    in_item_priority,
  output logic                                out_valid,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_front_value,
  output logic [spq_pkg::PRIO_FIELD_W-1:0]    out_front_priority,
  output logic                                out_is_empty,
  output logic [spq_pkg::COUNT_FIELD_W-1:0]   out_entry_count
);

  spq_pkg::ctl_t ctl;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  spq_datapath #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .in_cmd             (in_cmd),
    .in_item_value      (in_item_value),
    .in_item_priority   (in_item_priority),
    .out_status         (out_status),
    .out_front_value    (out_front_value),
    .out_front_priority (out_front_priority),
    .out_is_empty       (out_is_empty),
    .out_entry_count    (out_entry_count)
  );

endmodule

// ===== verif/stable_priority_queue_tb.sv =====
// Self-checking testbench for the stable priority queue: directed and random commands.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [spq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [spq_pkg::PRIO_FIELD_W-1:0] PRIO_MASK =
    spq_pkg::PRIO_FIELD_W'((64'd1 << spq_pkg::PRIO_BITS_DEFAULT) - 64'd1);
  localparam int QUIET_LIMIT = 200;
  localparam int SEGMENTS = 14;
  localparam int SEGMENT_LEN = 38;

  typedef struct {
    logic [spq_pkg::CMD_W-1:0]          cmd;
    logic signed [spq_pkg::VALUE_W-1:0] value;
    logic [spq_pkg::PRIO_FIELD_W-1:0]   prio;
    int unsigned                        gap;
  } cmd_word_t;

  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic [spq_pkg::VALUE_W-1:0]       front_value;
    logic [spq_pkg::PRIO_FIELD_W-1:0]  front_priority;
    logic                              is_empty;
    logic [spq_pkg::COUNT_FIELD_W-1:0] entry_count;
  } front_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [spq_pkg::CMD_W-1:0] in_cmd = spq_pkg::CMD_QUERY;
  logic signed [spq_pkg::VALUE_W-1:0] in_item_value = '0;
  logic [spq_pkg::PRIO_FIELD_W-1:0] in_item_priority = '0;
  logic out_valid;
  logic [spq_pkg::STATUS_W-1:0] out_status;
  logic signed [spq_pkg::VALUE_W-1:0] out_front_value;
  logic [spq_pkg::PRIO_FIELD_W-1:0] out_front_priority;
  logic out_is_empty;
  logic [spq_pkg::COUNT_FIELD_W-1:0] out_entry_count;

  cmd_word_t cmd_backlog[$];
  front_report_t predicted_reports[$];

  logic [spq_pkg::VALUE_W-1:0] shadow_value[spq_pkg::CAPACITY_DEFAULT];
  logic [spq_pkg::PRIO_FIELD_W-1:0] shadow_prio[spq_pkg::CAPACITY_DEFAULT];
  int shadow_count = 0;

  logic took_word = 1'b0;
  int unsigned gap_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  bit burst = 0;

  stable_priority_queue uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_item_value(in_item_value),
    .in_item_priority(in_item_priority),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_front_value(out_front_value),
    .out_front_priority(out_front_priority),
    .out_is_empty(out_is_empty),
    .out_entry_count(out_entry_count)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow queue and return the report it yields.
  function automatic front_report_t predict_step(input cmd_word_t w);
    front_report_t r;
    logic [spq_pkg::PRIO_FIELD_W-1:0] p;
    int pos;
    p = w.prio & PRIO_MASK;
    r.status = spq_pkg::STATUS_OK;
    if (w.cmd == spq_pkg::CMD_INSERT) begin
      if (shadow_count >= spq_pkg::CAPACITY_DEFAULT) begin
        r.status = spq_pkg::STATUS_FULL_DROP;
      end else begin
        pos = 0;
        // Go past every entry of greater or equal priority to keep ties in order.
        while (pos < shadow_count && shadow_prio[pos] >= p) pos++;
        for (int k = shadow_count; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k] = shadow_prio[k-1];
        end
        shadow_value[pos] = w.value;
        shadow_prio[pos] = p;
        shadow_count++;
      end
    end else if (w.cmd == spq_pkg::CMD_POP) begin
      if (shadow_count == 0) begin
        r.status = spq_pkg::STATUS_POP_EMPTY;
      end else begin
        for (int k = 0; k + 1 < shadow_count; k++) begin
          shadow_value[k] = shadow_value[k+1];
          shadow_prio[k] = shadow_prio[k+1];
        end
        shadow_count--;
      end
    end
    if (shadow_count == 0) begin
      r.front_value = spq_pkg::EMPTY_VALUE;
      r.front_priority = '0;
      r.is_empty = 1'b1;
    end else begin
      r.front_value = shadow_value[0];
      r.front_priority = shadow_prio[0];
      r.is_empty = 1'b0;
    end
    r.entry_count = shadow_count[spq_pkg::COUNT_FIELD_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string field,
                               input logic [spq_pkg::VALUE_W-1:0] expected_val,
                               input logic [spq_pkg::VALUE_W-1:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field,
               expected_val, actual_val);
      error_count++;
    end
  endtask

  task automatic push_word(input logic [spq_pkg::CMD_W-1:0] cmd,
                           input logic [spq_pkg::VALUE_W-1:0] value,
                           input logic [spq_pkg::PRIO_FIELD_W-1:0] prio);
    cmd_word_t w;
    w.cmd = cmd;
    w.value = value;
    w.prio = prio;
    w.gap = burst ? 0 : $urandom_range(0, 8);
    cmd_backlog.push_back(w);
  endtask

  // Driver: hold a word until accepted, then wait out its drawn gap.
  always @(negedge clk) begin
    cmd_word_t w;
    if (rst_n && !(start && !took_word)) begin
      if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        w = cmd_backlog.pop_front();
        in_cmd <= w.cmd;
        in_item_value <= w.value;
        in_item_priority <= w.prio;
        start <= 1'b1;
        gap_left <= w.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results first, then predict for a word accepted at this edge.
  always @(posedge clk) begin
    cmd_word_t w;
    front_report_t exp_r;
    if (!rst_n) begin
      took_word <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took_word <= start && !busy;
      if (out_valid) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %h value %h",
                   $time, out_status, out_front_value);
          error_count++;
        end else begin
          exp_r = predicted_reports.pop_front();
          compare_field("status", spq_pkg::VALUE_W'(exp_r.status),
                        spq_pkg::VALUE_W'(out_status));
          compare_field("front_value", exp_r.front_value, out_front_value);
          compare_field("front_priority", spq_pkg::VALUE_W'(exp_r.front_priority),
                        spq_pkg::VALUE_W'(out_front_priority));
          compare_field("is_empty", spq_pkg::VALUE_W'(exp_r.is_empty),
                        spq_pkg::VALUE_W'(out_is_empty));
          compare_field("entry_count", spq_pkg::VALUE_W'(exp_r.entry_count),
                        spq_pkg::VALUE_W'(out_entry_count));
        end
      end
      if (start && !busy) begin
        w.cmd = in_cmd;
        w.value = in_item_value;
        w.prio = in_item_priority;
        w.gap = 0;
        predicted_reports.push_back(predict_step(w));
      end
      if (out_valid || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time,
                 predicted_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int insert_pct;
    int prio_mode;
    logic [spq_pkg::VALUE_W-1:0] v;
    logic [spq_pkg::PRIO_FIELD_W-1:0] p;
    logic [spq_pkg::CMD_W-1:0] c;

    // Empty queue cases, then ties at both priority extremes.
    push_word(spq_pkg::CMD_QUERY, 32'h0, 8'h0);
    push_word(spq_pkg::CMD_POP, 32'h1234_5678, 8'hFF);
    push_word(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    push_word(spq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 8'hFF);
    push_word(spq_pkg::CMD_INSERT, 32'h8000_0000, 8'h00);
    push_word(spq_pkg::CMD_INSERT, 32'h0000_0000, 8'hFF);
    push_word(spq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 8'h00);
    push_word(spq_pkg::CMD_POP, 32'h0, 8'h0);
    // Fill to capacity, then overflow.
    for (int i = 0; i < 13; i++) begin
      case (i % 4)
        0: push_word(spq_pkg::CMD_INSERT, 32'h5555_5555, 8'h55);
        1: push_word(spq_pkg::CMD_INSERT, 32'hAAAA_AAAA, 8'hAA);
        2: push_word(spq_pkg::CMD_INSERT, $urandom, 8'h80);
        default: push_word(spq_pkg::CMD_INSERT, $urandom, 8'hFF);
      endcase
    end
    push_word(spq_pkg::CMD_INSERT, 32'h0BAD_F00D, 8'hFF);
    push_word(spq_pkg::CMD_QUERY, 32'h0, 8'h0);

    // Alternate insert-heavy and pop-heavy stretches to sweep full and empty.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      insert_pct = (seg % 2 == 0) ? $urandom_range(65, 85) : $urandom_range(10, 35);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        r = $urandom_range(0, 99);
        if (r < insert_pct) c = spq_pkg::CMD_INSERT;
        else if (r < 92) c = spq_pkg::CMD_POP;
        else if (r < 97) c = spq_pkg::CMD_QUERY;
        else c = CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 8) v = 32'h7FFF_FFFF;
        else if (r < 16) v = 32'h8000_0000;
        else v = $urandom;
        prio_mode = $urandom_range(0, 2);
        if (prio_mode == 0) p = spq_pkg::PRIO_FIELD_W'($urandom_range(0, 3));
        else if (prio_mode == 1) p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else p = spq_pkg::PRIO_FIELD_W'($urandom_range(0, 255));
        push_word(c, v, p);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || start || predicted_reports.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
